### sv/ddct_pkg.sv
// Package with shared types, register offsets and constants for the dual down-counter timer.
package ddct_pkg;

	// Number of timers built into the window (1 or 2).
	localparam int unsigned TIMER_COUNT = 2;
	localparam int unsigned TIMER_IDX_W = 1;

	// Request field widths.
	localparam int unsigned MODE_W = 2;
	localparam int unsigned OFFSET_W = 6;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned REG_OFF_W = 5;

	// Request kinds.
	localparam logic [MODE_W-1:0] MODE_READ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	// Register offsets inside one timer's 32-byte slot.
	localparam logic [REG_OFF_W-1:0] REG_LOAD = 5'h00;
	localparam logic [REG_OFF_W-1:0] REG_VALUE = 5'h04;
	localparam logic [REG_OFF_W-1:0] REG_CONTROL = 5'h08;
	localparam logic [REG_OFF_W-1:0] REG_INTCLR = 5'h0c;
	localparam logic [REG_OFF_W-1:0] REG_RIS = 5'h10;
	localparam logic [REG_OFF_W-1:0] REG_MIS = 5'h14;
	localparam logic [REG_OFF_W-1:0] REG_BGLOAD = 5'h18;

	// Control word bit positions.
	localparam int unsigned CTL_SIZE_BIT = 1;
	localparam int unsigned CTL_INTEN_BIT = 5;
	localparam int unsigned CTL_MODE_BIT = 6;
	localparam int unsigned CTL_ENABLE_BIT = 7;

	// Reset and reload values.
	localparam logic [DATA_W-1:0] LOAD_RESET = 32'h0000_0000;
	localparam logic [DATA_W-1:0] COUNT_RESET = 32'hffff_ffff;
	localparam logic [DATA_W-1:0] CONTROL_RESET = 32'h0000_0020;
	localparam logic [DATA_W-1:0] FREE_RUN_32 = 32'hffff_ffff;
	localparam logic [DATA_W-1:0] FREE_RUN_16 = 32'h0000_ffff;

	// Accepted request as held in the input register.
	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [OFFSET_W-1:0] offset;
		logic [DATA_W-1:0]   write_data;
		logic [DATA_W-1:0]   tick_count;
	} req_t;

	// Result as held in the output register.
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              handled;
		logic              irq_level;
	} rsp_t;

	// Command from the decoder to one timer.
	typedef struct packed {
		logic                 apply;
		logic                 sel;
		logic                 is_read;
		logic                 is_write;
		logic                 is_tick;
		logic [REG_OFF_W-1:0] reg_off;
		logic [DATA_W-1:0]    wdata;
		logic [DATA_W-1:0]    ticks;
	} timer_cmd_t;

	// Status from one timer back to the decoder.
	typedef struct packed {
		logic [DATA_W-1:0] rd_data;
		logic              rd_hit;
		logic              wr_hit;
		logic              irq_next;
	} timer_stat_t;

endpackage

### sv/ddct_req_if.sv
// Request channel interface carrying bus accesses and ticks into the timer block.
interface ddct_req_if;
	logic                               valid;
	logic                               ready;
	logic [ddct_pkg::MODE_W-1:0]        mode;
	logic [ddct_pkg::OFFSET_W-1:0]      offset;
	logic [ddct_pkg::DATA_W-1:0]        write_data;
	logic [ddct_pkg::DATA_W-1:0]        tick_count;

	modport source(output valid, mode, offset, write_data, tick_count, input ready);
	modport sink(input valid, mode, offset, write_data, tick_count, output ready);
endinterface

### sv/ddct_rsp_if.sv
// Result channel interface carrying read data, decode status and the interrupt line.
interface ddct_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ddct_pkg::DATA_W-1:0]  read_data;
	logic                         handled;
	logic                         irq_level;

	modport source(output valid, read_data, handled, irq_level, input ready);
	modport sink(input valid, read_data, handled, irq_level, output ready);
endinterface

### sv/dual_down_counter_timer_unit.sv
// Top level of the dual down-counter timer: request register, timer decode and result register.
// The block takes one request per clock cycle (a bus read, a bus write or a tick of N counts) while results are taken.
// A request accepted at a clock edge sits in the input register, where each
// timer's compare, subtract and register update run; its result is written to the output
// register, and the timer state updated, once the result register is free, so the sustained
// rate is one request per cycle as long as the result side keeps taking them. When the
// result register is full and not being taken, an occupied input register holds and ready
// drops.
// The irq_level in each result is the combined interrupt line after that request.
module dual_down_counter_timer_unit (
	input  logic              clk,
	input  logic              arst_n,
	ddct_req_if.sink          req,
	ddct_rsp_if.source        rsp
);

	logic                 valid_s1;
	ddct_pkg::req_t       req_s1;
	logic                 rsp_valid_q;
	ddct_pkg::rsp_t       rsp_q;

	logic                 advance;
	logic                 in_fire;
	logic [ddct_pkg::TIMER_IDX_W-1:0] timer_idx;
	logic                 timer_ok;
	logic                 is_read;
	logic                 is_write;
	logic                 is_tick;

	ddct_pkg::timer_cmd_t  cmd [ddct_pkg::TIMER_COUNT];
	ddct_pkg::timer_stat_t stat [ddct_pkg::TIMER_COUNT];
	ddct_pkg::rsp_t        rsp_d;

	// Handshake: the input register moves on whenever the result register is free.
	assign advance = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign in_fire = req.valid && req.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1.mode <= req.mode;
			req_s1.offset <= req.offset;
			req_s1.write_data <= req.write_data;
			req_s1.tick_count <= req.tick_count;
		end
	end

	// Window decode: the top offset bit picks the timer.
	assign timer_idx = req_s1.offset[ddct_pkg::OFFSET_W-1 -: ddct_pkg::TIMER_IDX_W];
	assign timer_ok = {1'b0, timer_idx} < (ddct_pkg::TIMER_IDX_W+1)'(ddct_pkg::TIMER_COUNT);
	assign is_read = req_s1.mode == ddct_pkg::MODE_READ;
	assign is_write = req_s1.mode == ddct_pkg::MODE_WRITE;
	assign is_tick = req_s1.mode == ddct_pkg::MODE_TICK;

	// Timer instances.
	for (genvar g = 0; g < ddct_pkg::TIMER_COUNT; g++) begin : g_timer
		always_comb begin
			cmd[g].apply = valid_s1 && advance;
			cmd[g].sel = timer_ok && (timer_idx == ddct_pkg::TIMER_IDX_W'(g));
			cmd[g].is_read = is_read;
			cmd[g].is_write = is_write;
			cmd[g].is_tick = is_tick;
			cmd[g].reg_off = req_s1.offset[ddct_pkg::REG_OFF_W-1:0];
			cmd[g].wdata = req_s1.write_data;
			cmd[g].ticks = req_s1.tick_count;
		end

		ddct_timer u_timer (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[g]),
			.stat   (stat[g])
		);
	end

	// Merge timer status; at most one timer is selected for a bus access.
	always_comb begin
		rsp_d = '0;
		for (int i = 0; i < ddct_pkg::TIMER_COUNT; i++) begin
			rsp_d.read_data = rsp_d.read_data | stat[i].rd_data;
			rsp_d.handled = rsp_d.handled | stat[i].rd_hit | stat[i].wr_hit;
			rsp_d.irq_level = rsp_d.irq_level | stat[i].irq_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.read_data = rsp_q.read_data;
	assign rsp.handled = rsp_q.handled;
	assign rsp.irq_level = rsp_q.irq_level;

endmodule

### sv/ddct_timer.sv
// One down-counting timer: its registers, bus read/write decode and tick handling.
module ddct_timer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ddct_pkg::timer_cmd_t   cmd,
	output ddct_pkg::timer_stat_t  stat
);

	logic [ddct_pkg::DATA_W-1:0] load_q;
	logic [ddct_pkg::DATA_W-1:0] count_q;
	logic [ddct_pkg::DATA_W-1:0] ctl_q;
	logic                        running_q;
	logic                        raw_q;

	logic [ddct_pkg::DATA_W-1:0] load_d;
	logic [ddct_pkg::DATA_W-1:0] count_d;
	logic [ddct_pkg::DATA_W-1:0] ctl_d;
	logic                        running_d;
	logic                        raw_d;

	logic [ddct_pkg::DATA_W-1:0] reload_cur;
	logic [ddct_pkg::DATA_W-1:0] reload_new;
	logic [ddct_pkg::DATA_W-1:0] rd_val;
	logic                        rd_ok;
	logic                        wr_ok;
	logic                        do_read;
	logic                        do_write;
	logic                        new_enable;

	assign do_read = cmd.sel && cmd.is_read;
	assign do_write = cmd.sel && cmd.is_write;
	assign new_enable = cmd.wdata[ddct_pkg::CTL_ENABLE_BIT];

	// Reload value under the current control word, used on expiry.
	always_comb begin
		if (ctl_q[ddct_pkg::CTL_MODE_BIT]) begin
			reload_cur = load_q;
		end else if (ctl_q[ddct_pkg::CTL_SIZE_BIT]) begin
			reload_cur = ddct_pkg::FREE_RUN_32;
		end else begin
			reload_cur = ddct_pkg::FREE_RUN_16;
		end
	end

	// Reload value under the control word being written, used when enable rises.
	always_comb begin
		if (cmd.wdata[ddct_pkg::CTL_MODE_BIT]) begin
			reload_new = load_q;
		end else if (cmd.wdata[ddct_pkg::CTL_SIZE_BIT]) begin
			reload_new = ddct_pkg::FREE_RUN_32;
		end else begin
			reload_new = ddct_pkg::FREE_RUN_16;
		end
	end

	// Register read mux.
	always_comb begin
		rd_val = '0;
		rd_ok = 1'b1;
		case (cmd.reg_off)
			ddct_pkg::REG_LOAD: begin
				rd_val = load_q;
			end
			ddct_pkg::REG_VALUE: begin
				rd_val = count_q;
			end
			ddct_pkg::REG_CONTROL: begin
				rd_val = ctl_q;
			end
			ddct_pkg::REG_RIS: begin
				rd_val = {{(ddct_pkg::DATA_W-1){1'b0}}, raw_q};
			end
			ddct_pkg::REG_MIS: begin
				rd_val = {{(ddct_pkg::DATA_W-1){1'b0}},
					raw_q & ctl_q[ddct_pkg::CTL_INTEN_BIT]};
			end
			ddct_pkg::REG_BGLOAD: begin
				rd_val = load_q;
			end
			default: begin
				rd_ok = 1'b0;
			end
		endcase
	end

	// Next-state logic for writes and ticks.
	always_comb begin
		load_d = load_q;
		count_d = count_q;
		ctl_d = ctl_q;
		running_d = running_q;
		raw_d = raw_q;
		wr_ok = 1'b0;
		if (do_write) begin
			case (cmd.reg_off)
				ddct_pkg::REG_LOAD: begin
					wr_ok = 1'b1;
					load_d = cmd.wdata;
					count_d = cmd.wdata;
				end
				ddct_pkg::REG_VALUE: begin
					wr_ok = 1'b1;
				end
				ddct_pkg::REG_CONTROL: begin
					wr_ok = 1'b1;
					ctl_d = cmd.wdata;
					running_d = new_enable;
					if (new_enable && !running_q) begin
						count_d = reload_new;
					end
				end
				ddct_pkg::REG_INTCLR: begin
					wr_ok = 1'b1;
					raw_d = 1'b0;
				end
				ddct_pkg::REG_BGLOAD: begin
					wr_ok = 1'b1;
					load_d = cmd.wdata;
				end
				default: begin
					wr_ok = 1'b0;
				end
			endcase
		end else if (cmd.is_tick && running_q) begin
			if (count_q <= cmd.ticks) begin
				count_d = reload_cur;
				raw_d = 1'b1;
			end else begin
				count_d = count_q - cmd.ticks;
			end
		end
	end

	// State registers, updated when the request retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= ddct_pkg::LOAD_RESET;
			count_q <= ddct_pkg::COUNT_RESET;
			ctl_q <= ddct_pkg::CONTROL_RESET;
			running_q <= 1'b0;
			raw_q <= 1'b0;
		end else if (cmd.apply) begin
			load_q <= load_d;
			count_q <= count_d;
			ctl_q <= ctl_d;
			running_q <= running_d;
			raw_q <= raw_d;
		end
	end

	// Status back to the decoder; the interrupt reflects the state after this request.
	always_comb begin
		stat.rd_hit = do_read && rd_ok;
		stat.rd_data = (do_read && rd_ok) ? rd_val : '0;
		stat.wr_hit = wr_ok;
		stat.irq_next = raw_d & ctl_d[ddct_pkg::CTL_INTEN_BIT];
	end

endmodule
